// ===== src/egfc_pkg.sv =====
// package with shared constants and types for the energy gated frame capture
`timescale 1ns / 1ps

package egfc_pkg;

    localparam int WINDOW_LEN  = 20;
    localparam int SAMPLE_BITS = 12;

    localparam int WIN_AW = $clog2(WINDOW_LEN);
    localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_LEN);
    localparam int THR_W  = 17;
    localparam int IDX_W  = 10;
    localparam int CMP_W  = (SUM_W > THR_W) ? SUM_W : THR_W;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(6206);
    localparam logic [IDX_W-1:0] LEN_RESET = IDX_W'(205);

    typedef enum logic
    {
        REG_THRESHOLD = 1'b0,
        REG_FRAME_LEN = 1'b1
    } reg_sel_t;

    typedef struct packed
    {
        logic [SAMPLE_BITS-1:0] sample_value;
        logic                   stored;
        logic [IDX_W-1:0]       position;
        logic                   frame_done;
        logic                   frame_dropped;
        logic                   burst_active;
    } result_t;

endpackage

// ===== src/egfc_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module egfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/energy_gated_frame_capture.sv =====
// top level of the energy gated frame capture block
`timescale 1ns / 1ps

// Energy gated frame capture. Each ADC word on the input channel yields
// exactly one result word. The block takes one word per clock cycle
// sustained while out_ready does not stall the output; a word passes
// through the stage 1 registers and then the result register to the output.
// The rate is set by the window memory, which holds the latest samples in a
// ring and gives one read (the oldest sample) and one write (the new sample)
// per cycle. The running sum becomes valid for testing once the window is
// full; before that no detector decision is made. A sum above threshold_sum
// makes the detector active, a sum at or below it returns it to idle after
// the first burst. One frame of frame_length samples is flagged per burst;
// a partial frame is reported as dropped when the burst ends.
// Registers: threshold_sum at byte address 0, frame_length at byte address 4.
// Write configuration only while no words are in flight.

module energy_gated_frame_capture
    import egfc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_AW-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready,

    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [SAMPLE_BITS-1:0]   sample,

    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [SAMPLE_BITS-1:0]   sample_value,
    output logic                     stored,
    output logic [IDX_W-1:0]         position,
    output logic                     frame_done,
    output logic                     frame_dropped,
    output logic                     burst_active
);

    // configuration
    logic [THR_W-1:0] thr_reg;
    logic [IDX_W-1:0] len_reg;
    logic             cfg_we;
    reg_sel_t         cfg_sel;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_sel = reg_sel_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
            len_reg <= LEN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_sel)
                REG_THRESHOLD: thr_reg <= pwdata[THR_W-1:0];
                REG_FRAME_LEN: len_reg <= pwdata[IDX_W-1:0];
                default:       thr_reg <= thr_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (cfg_sel)
            REG_THRESHOLD: prdata = APB_DW'(thr_reg);
            REG_FRAME_LEN: prdata = APB_DW'(len_reg);
            default:       prdata = '0;
        endcase
    end

    // stage 1: ring pointer and window read
    logic [WIN_AW-1:0]      ptr_reg;
    logic                   full_reg;
    logic                   s1_valid_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic [WIN_AW-1:0]      s1_addr_reg;
    logic                   s1_full_reg;
    logic                   s1_tested_reg;
    logic [SAMPLE_BITS-1:0] old_sample;

    logic                   out_free;
    logic                   s1_move;
    logic                   in_take;
    logic                   ptr_last;

    result_t                res_reg;
    result_t                res_next;

    assign out_free = !out_valid || out_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;
    assign in_take  = in_valid && in_ready;
    assign ptr_last = (ptr_reg == WIN_AW'(WINDOW_LEN - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg      <= '0;
            full_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                ptr_reg <= ptr_last ? '0 : ptr_reg + 1'b1;
                if (ptr_last)
                begin
                    full_reg <= 1'b1;
                end
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_sample_reg <= sample;
            s1_addr_reg   <= ptr_reg;
            s1_full_reg   <= full_reg;
            s1_tested_reg <= full_reg || ptr_last;
        end
    end

    egfc_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_LEN)
    ) u_window (
        .clk   (clk),
        .we    (s1_move),
        .waddr (s1_addr_reg),
        .wdata (s1_sample_reg),
        .re    (in_take),
        .raddr (ptr_reg),
        .rdata (old_sample)
    );

    // stage 2: running sum, detector and frame control
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic             seen_reg;
    logic             seen_next;
    logic             idle_reg;
    logic             idle_next;
    logic             cap_reg;
    logic             cap_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             taken_reg;
    logic             taken_next;
    logic             dropping;
    logic [IDX_W-1:0] idx_inc;
    logic             above;

    always_comb
    begin
        sum_next   = s1_full_reg ? (sum_reg - SUM_W'(old_sample) + SUM_W'(s1_sample_reg))
                                 : (sum_reg + SUM_W'(s1_sample_reg));
        above      = (CMP_W'(sum_next) > CMP_W'(thr_reg));
        seen_next  = seen_reg;
        idle_next  = idle_reg;
        cap_next   = cap_reg;
        idx_next   = idx_reg;
        taken_next = taken_reg;
        dropping   = 1'b0;
        idx_inc    = idx_reg + 1'b1;

        res_next               = '0;
        res_next.sample_value  = s1_sample_reg;

        if (s1_tested_reg)
        begin
            if (above)
            begin
                if (idle_reg)
                begin
                    seen_next = 1'b1;
                    idle_next = 1'b0;
                end
            end
            else if (seen_reg)
            begin
                idle_next = 1'b1;
            end
            if (seen_next && !idle_next)
            begin
                cap_next = 1'b1;
            end
            if (seen_next && idle_next)
            begin
                dropping = 1'b1;
            end
        end

        if (dropping)
        begin
            res_next.frame_dropped = cap_next && !taken_reg && (idx_reg != '0);
            idx_next   = '0;
            cap_next   = 1'b0;
            taken_next = 1'b0;
        end
        else if (cap_next && !taken_reg)
        begin
            res_next.stored   = 1'b1;
            res_next.position = idx_reg;
            if (idx_inc == len_reg)
            begin
                res_next.frame_done = 1'b1;
                idx_next   = '0;
                taken_next = 1'b1;
            end
            else
            begin
                idx_next = idx_inc;
            end
        end

        res_next.burst_active = !idle_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            seen_reg  <= 1'b0;
            idle_reg  <= 1'b1;
            cap_reg   <= 1'b0;
            idx_reg   <= '0;
            taken_reg <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (s1_move)
            begin
                sum_reg   <= sum_next;
                seen_reg  <= seen_next;
                idle_reg  <= idle_next;
                cap_reg   <= cap_next;
                idx_reg   <= idx_next;
                taken_reg <= taken_next;
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            res_reg <= res_next;
        end
    end

    assign sample_value  = res_reg.sample_value;
    assign stored        = res_reg.stored;
    assign position      = res_reg.position;
    assign frame_done    = res_reg.frame_done;
    assign frame_dropped = res_reg.frame_dropped;
    assign burst_active  = res_reg.burst_active;

    // checks
    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !stored) |-> (position == '0))
        else $error("position nonzero for a word that was not stored");

    a_done_stored: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_done) |-> stored)
        else $error("frame completed without storing");

    a_drop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_dropped) |-> (!stored && !burst_active))
        else $error("frame dropped while active or storing");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while pipeline is stalled");

    a_capture_seen: assert property (@(posedge clk) disable iff (!rst_n)
        cap_reg |-> (seen_reg && !idle_reg))
        else $error("capturing outside a burst");

endmodule
